FILE: src/rmg_pkg.sv
`timescale 1ns / 1ps
// Package of the rotation matrix generator: formats, derived widths, codes,
// the CORDIC arctangent table and the structs passed between the parts.
// Has no dependencies; every other file of the block uses it.
package rmg_pkg;

  // Fraction bits of the input angle, of the outputs, and CORDIC depth.
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS   = 16;
  localparam int CORDIC_STAGES   = 16;

  // Field widths fixed by the interface.
  localparam int ANGLE_W = 32;
  localparam int AXIS_W  = 2;
  localparam int ENTRY_W = 18;

  // Axis codes.
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // Angle reduction constants, in input angle units.
  localparam longint FULL_DEG    = longint'(360) << ANGLE_FRAC_BITS;
  localparam longint QUARTER_DEG = longint'(90) << ANGLE_FRAC_BITS;
  localparam longint HALF_DEG    = longint'(180) << ANGLE_FRAC_BITS;
  localparam longint IN_SPAN     = longint'(1) << (ANGLE_W - 1);
  localparam longint OFFSET_MULT = (IN_SPAN + FULL_DEG - 1) / FULL_DEG;
  localparam longint OFFSET      = OFFSET_MULT * FULL_DEG;
  localparam longint SUM_MAX     = IN_SPAN - 1 + OFFSET;
  localparam int     SUM_W       = $clog2(SUM_MAX + 1);
  localparam int     RED_STEPS   = $clog2(SUM_MAX / FULL_DEG + 1);
  localparam int     FULL_W      = $clog2(FULL_DEG);
  localparam int     REM_W       = $clog2(QUARTER_DEG);

  // Degrees to radians, pi/180 in Q.32, and the product width.
  localparam longint DEG2RAD_Q32 = 64'd74961321;
  localparam int     DEG_W       = $clog2(DEG2RAD_Q32 + 1);
  localparam int     PROD_W      = REM_W + DEG_W;
  localparam int     RAD_SHIFT   = ANGLE_FRAC_BITS + 2;

  // CORDIC datapath in Q.30.
  localparam int     XY_W            = 33;
  localparam int     Z_W             = 33;
  localparam longint CORDIC_GAIN_Q30 = 64'd652032874;

  // Rounding from Q.30 to the output format.
  localparam int     CV_W    = OUT_FRAC_BITS + 2;
  localparam int     RND_SH  = (OUT_FRAC_BITS >= 30) ? 0 : 30 - OUT_FRAC_BITS;
  localparam longint RND_ADD = (OUT_FRAC_BITS >= 30) ? 0 :
                               (longint'(1) << (29 - OUT_FRAC_BITS));
  localparam longint ONE_OUT = longint'(1) << OUT_FRAC_BITS;

  // Queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified item: radians in Q.30, quadrant and axis code.
  typedef struct packed {
    logic signed [Z_W-1:0] z;
    logic [1:0]            quad;
    logic [AXIS_W-1:0]     axis;
  } rmg_work_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic can_push;
    logic has_data;
  } rmg_qstat_t;

  // atan(2^-i) truncated to Q.30; zero beyond the table.
  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] a;
    case (i)
      0:  a = 31'd843314856;
      1:  a = 31'd497837829;
      2:  a = 31'd263043836;
      3:  a = 31'd133525158;
      4:  a = 31'd67021686;
      5:  a = 31'd33543515;
      6:  a = 31'd16775850;
      7:  a = 31'd8388437;
      8:  a = 31'd4194282;
      9:  a = 31'd2097149;
      10: a = 31'd1048575;
      11: a = 31'd524287;
      12: a = 31'd262143;
      13: a = 31'd131071;
      14: a = 31'd65535;
      15: a = 31'd32767;
      16: a = 31'd16383;
      17: a = 31'd8191;
      18: a = 31'd4095;
      19: a = 31'd2047;
      20: a = 31'd1023;
      21: a = 31'd511;
      22: a = 31'd255;
      23: a = 31'd127;
      24: a = 31'd63;
      25: a = 31'd31;
      26: a = 31'd15;
      27: a = 31'd7;
      28: a = 31'd3;
      29: a = 31'd1;
      default: a = 31'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: src/rmg_intf.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the rotation matrix generator.
// Depends on rmg_pkg for the field widths.
interface rmg_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmg_pkg::ANGLE_W-1:0]  angle_deg;
  logic        [rmg_pkg::AXIS_W-1:0]   axis;

  modport source (output valid, angle_deg, axis, input ready);
  modport sink   (input valid, angle_deg, axis, output ready);
endinterface

interface rmg_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rmg_pkg::ENTRY_W-1:0] m00;
  logic signed [rmg_pkg::ENTRY_W-1:0] m01;
  logic signed [rmg_pkg::ENTRY_W-1:0] m02;
  logic signed [rmg_pkg::ENTRY_W-1:0] m10;
  logic signed [rmg_pkg::ENTRY_W-1:0] m11;
  logic signed [rmg_pkg::ENTRY_W-1:0] m12;
  logic signed [rmg_pkg::ENTRY_W-1:0] m20;
  logic signed [rmg_pkg::ENTRY_W-1:0] m21;
  logic signed [rmg_pkg::ENTRY_W-1:0] m22;
  logic                               bad_axis;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, bad_axis,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, bad_axis,
                  output ready);
endinterface

FILE: src/axis_rotation_matrix_gen.sv
`timescale 1ns / 1ps
// Top level of the elementary rotation matrix generator: front, queue, back.
// Depends on rmg_pkg, rmg_intf, rmg_front, rmg_queue and rmg_back.
//
// Give it an angle in degrees (signed, 16 fraction bits) and an axis code
// (0 x, 1 y, 2 z) and it returns the nine entries of the 3x3 rotation
// matrix about that axis in signed Q1.16, with bad_axis set and all entries
// zero for axis code 3. The block takes one request per clock and returns
// one result per clock while the result side is ready. A request passes
// through the front pipeline, the queue and the back pipeline, which
// holds the CORDIC pipeline, one rotation per stage. The front and back
// stall independently, decoupled by a two-entry queue, and a waiting
// result does not stop new requests until the queue has filled and an
// item waits in the front pipeline's last stage.
module axis_rotation_matrix_gen (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmg_in_if.sink     req_i,
  rmg_out_if.source  res_o
);

  rmg_pkg::rmg_qstat_t qstat;
  rmg_pkg::rmg_work_t  push_data;
  rmg_pkg::rmg_work_t  pop_data;
  logic                push;
  logic                pop;

  // Angle reduction and classification.
  rmg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .qstat_i (qstat),
    .push_o  (push),
    .work_o  (push_data)
  );

  // Decoupling queue.
  rmg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_data),
    .pop_i   (pop),
    .stat_o  (qstat),
    .rdata_o (pop_data)
  );

  // CORDIC and matrix assembly.
  rmg_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .qstat_i (qstat),
    .work_i  (pop_data),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

FILE: src/rmg_front.sv
`timescale 1ns / 1ps
// Front part: takes requests, reduces the angle modulo 360 degrees, splits off
// the quadrant and converts the remainder to Q.30 radians. Uses rmg_pkg, rmg_intf.
module rmg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  rmg_in_if.sink              req_i,
  input  rmg_pkg::rmg_qstat_t qstat_i,
  output logic                push_o,
  output rmg_pkg::rmg_work_t  work_o
);

  // Stage map: offset add, reduction steps, two quadrant steps, multiply, round.
  localparam int ST_QA   = rmg_pkg::RED_STEPS + 1;
  localparam int ST_QB   = ST_QA + 1;
  localparam int ST_MUL  = ST_QB + 1;
  localparam int ST_RND  = ST_MUL + 1;
  localparam int NSTAGE  = ST_RND + 1;
  localparam int SUM_W   = rmg_pkg::SUM_W;

  logic                          fen;
  logic [NSTAGE-1:0]             vld_q;
  logic [rmg_pkg::AXIS_W-1:0]    axis_q [NSTAGE];
  logic [SUM_W-1:0]              red_q  [rmg_pkg::RED_STEPS+1];
  logic [rmg_pkg::FULL_W-1:0]    ra_q;
  logic                          qhi_q;
  logic [rmg_pkg::REM_W-1:0]     rb_q;
  logic [1:0]                    qb_q;
  logic [rmg_pkg::PROD_W-1:0]    prod_q;
  logic [1:0]                    qm_q;
  rmg_pkg::rmg_work_t            work_q;
  logic [SUM_W:0]                sum_d;
  logic [rmg_pkg::FULL_W-1:0]    rem_full;
  logic [rmg_pkg::FULL_W:0]      ra_d;
  logic [rmg_pkg::FULL_W:0]      rb_d;
  logic [rmg_pkg::PROD_W:0]      rnd_d;

  // The whole front advances unless its last stage holds an item the queue refuses.
  assign fen         = !vld_q[NSTAGE-1] || qstat_i.can_push;
  assign req_i.ready = fen;
  assign push_o      = vld_q[NSTAGE-1] && qstat_i.can_push;
  assign work_o      = work_q;

  // Valid bits and axis codes travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (fen) begin
      vld_q <= {vld_q[NSTAGE-2:0], req_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fen) begin
      axis_q[0] <= req_i.axis;
      for (int j = 1; j < NSTAGE; j++) begin
        axis_q[j] <= axis_q[j-1];
      end
    end
  end

  // Offset the signed angle by a multiple of a full turn so it is never negative.
  assign sum_d = (SUM_W+1)'(req_i.angle_deg) + (SUM_W+1)'(rmg_pkg::OFFSET);

  always_ff @(posedge clk_i) begin
    if (fen) begin
      red_q[0] <= sum_d[SUM_W-1:0];
    end
  end

  // Restoring reduction: one compare and subtract of a shifted full turn per stage.
  for (genvar j = 0; j < rmg_pkg::RED_STEPS; j++) begin : g_red
    localparam logic [SUM_W:0] STEP_C =
      (SUM_W+1)'(rmg_pkg::FULL_DEG << (rmg_pkg::RED_STEPS - 1 - j));
    logic [SUM_W:0] diff;
    assign diff = {1'b0, red_q[j]} - STEP_C;
    always_ff @(posedge clk_i) begin
      if (fen) begin
        red_q[j+1] <= diff[SUM_W] ? red_q[j] : diff[SUM_W-1:0];
      end
    end
  end

  // Quadrant, high bit: remainder at or above a half turn.
  assign rem_full = red_q[rmg_pkg::RED_STEPS][rmg_pkg::FULL_W-1:0];
  assign ra_d     = {1'b0, rem_full} - (rmg_pkg::FULL_W+1)'(rmg_pkg::HALF_DEG);

  // Quadrant, low bit: what is left at or above a quarter turn.
  assign rb_d     = {1'b0, ra_q} - (rmg_pkg::FULL_W+1)'(rmg_pkg::QUARTER_DEG);

  // Round the radian product half up to Q.30.
  assign rnd_d    = {1'b0, prod_q} + (rmg_pkg::PROD_W+1)'(longint'(1) << (rmg_pkg::RAD_SHIFT - 1));

  always_ff @(posedge clk_i) begin
    if (fen) begin
      qhi_q       <= !ra_d[rmg_pkg::FULL_W];
      ra_q        <= ra_d[rmg_pkg::FULL_W] ? rem_full : ra_d[rmg_pkg::FULL_W-1:0];
      qb_q        <= {qhi_q, !rb_d[rmg_pkg::FULL_W]};
      rb_q        <= rb_d[rmg_pkg::FULL_W] ? rmg_pkg::REM_W'(ra_q) : rmg_pkg::REM_W'(rb_d);
      prod_q      <= rmg_pkg::PROD_W'(rb_q) * rmg_pkg::PROD_W'(rmg_pkg::DEG2RAD_Q32);
      qm_q        <= qb_q;
      work_q.z    <= rmg_pkg::Z_W'(rnd_d >> rmg_pkg::RAD_SHIFT);
      work_q.quad <= qm_q;
      work_q.axis <= axis_q[ST_MUL];
    end
  end

endmodule

FILE: src/rmg_queue.sv
`timescale 1ns / 1ps
// Short queue of classified items between the front and back parts.
// Uses rmg_pkg for the item struct and depth.
module rmg_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rmg_pkg::rmg_work_t  wdata_i,
  input  logic                pop_i,
  output rmg_pkg::rmg_qstat_t stat_o,
  output rmg_pkg::rmg_work_t  rdata_o
);

  rmg_pkg::rmg_work_t          mem_q [rmg_pkg::QUEUE_DEPTH];
  logic [rmg_pkg::QPTR_W-1:0]  wr_ptr_q;
  logic [rmg_pkg::QPTR_W-1:0]  rd_ptr_q;
  logic [rmg_pkg::QCNT_W-1:0]  count_q;

  // Status comes from registers only, so neither side sees the other combinationally.
  assign stat_o.can_push = count_q < rmg_pkg::QCNT_W'(rmg_pkg::QUEUE_DEPTH);
  assign stat_o.has_data = count_q != '0;
  assign rdata_o         = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // The fill count never passes the depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= rmg_pkg::QCNT_W'(rmg_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  // Nothing is taken from an empty queue.
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  // Nothing is written into a full queue.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q != rmg_pkg::QCNT_W'(rmg_pkg::QUEUE_DEPTH))
    else $error("push into full queue");

endmodule

FILE: src/rmg_back.sv
`timescale 1ns / 1ps
// Back part: pipelined CORDIC sine and cosine, quadrant mapping, rounding and
// matrix assembly into the result register. Uses rmg_pkg and rmg_intf.
module rmg_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmg_pkg::rmg_qstat_t qstat_i,
  input  rmg_pkg::rmg_work_t  work_i,
  output logic                pop_o,
  rmg_out_if.source           res_o
);

  localparam int CS     = rmg_pkg::CORDIC_STAGES;
  localparam int XY_W   = rmg_pkg::XY_W;
  localparam int Z_W    = rmg_pkg::Z_W;
  localparam int CV_W   = rmg_pkg::CV_W;
  localparam int ENT_W  = rmg_pkg::ENTRY_W;
  // Stages: CS+1 CORDIC registers, then the rounding register.
  localparam int NSTAGE = CS + 2;
  localparam logic signed [CV_W-1:0] ONE_C = CV_W'(rmg_pkg::ONE_OUT);

  logic                         en;
  logic [NSTAGE-1:0]            vld_q;
  logic [1:0]                   quad_q [CS+1];
  logic [rmg_pkg::AXIS_W-1:0]   axis_q [NSTAGE];
  logic signed [XY_W-1:0]       x_q    [CS+1];
  logic signed [XY_W-1:0]       y_q    [CS+1];
  logic signed [Z_W-1:0]        z_q    [CS+1];
  logic signed [CV_W-1:0]       cv_q;
  logic signed [CV_W-1:0]       sv_q;
  logic signed [XY_W:0]         c_d;
  logic signed [XY_W:0]         s_d;
  logic                         ovld_q;
  logic signed [ENT_W-1:0]      m_q    [9];
  logic signed [ENT_W-1:0]      m_d    [9];
  logic                         bad_q;
  logic                         bad_d;
  logic signed [ENT_W-1:0]      one_e;
  logic signed [ENT_W-1:0]      c_e;
  logic signed [ENT_W-1:0]      s_e;
  logic signed [ENT_W-1:0]      ns_e;

  // Q.30 to output format: round half up, then clamp to plus or minus one.
  function automatic logic signed [CV_W-1:0] to_out(input logic signed [XY_W:0] v);
    logic signed [XY_W+1:0] r;
    logic signed [XY_W+1:0] one_w;
    one_w = (XY_W+2)'(rmg_pkg::ONE_OUT);
    r = ((XY_W+2)'(v) + (XY_W+2)'(rmg_pkg::RND_ADD)) >>> rmg_pkg::RND_SH;
    if (r > one_w) begin
      r = one_w;
    end else if (r < -one_w) begin
      r = -one_w;
    end
    return CV_W'(r);
  endfunction

  // The whole back advances whenever the result register is free or being taken.
  assign en    = !ovld_q || res_o.ready;
  assign pop_o = en && qstat_i.has_data;

  // Valid bits and codes follow the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      ovld_q <= 1'b0;
    end else if (en) begin
      vld_q  <= {vld_q[NSTAGE-2:0], pop_o};
      ovld_q <= vld_q[NSTAGE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      axis_q[0] <= work_i.axis;
      quad_q[0] <= work_i.quad;
      x_q[0]    <= XY_W'(rmg_pkg::CORDIC_GAIN_Q30);
      y_q[0]    <= '0;
      z_q[0]    <= work_i.z;
      for (int j = 1; j < NSTAGE; j++) begin
        axis_q[j] <= axis_q[j-1];
      end
      for (int j = 1; j <= CS; j++) begin
        quad_q[j] <= quad_q[j-1];
      end
    end
  end

  // One CORDIC rotation per stage.
  for (genvar i = 0; i < CS; i++) begin : g_cordic
    localparam logic signed [Z_W-1:0] ATAN_C = Z_W'(rmg_pkg::atan_q30(i));
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!z_q[i][Z_W-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - ATAN_C;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + ATAN_C;
        end
      end
    end
  end

  // Map the first-quadrant result to the full angle.
  always_comb begin
    case (quad_q[CS])
      2'd0: begin
        c_d = (XY_W+1)'(x_q[CS]);
        s_d = (XY_W+1)'(y_q[CS]);
      end
      2'd1: begin
        c_d = -(XY_W+1)'(y_q[CS]);
        s_d = (XY_W+1)'(x_q[CS]);
      end
      2'd2: begin
        c_d = -(XY_W+1)'(x_q[CS]);
        s_d = -(XY_W+1)'(y_q[CS]);
      end
      default: begin
        c_d = (XY_W+1)'(y_q[CS]);
        s_d = -(XY_W+1)'(x_q[CS]);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cv_q <= to_out(c_d);
      sv_q <= to_out(s_d);
    end
  end

  // Matrix assembly by axis; an unknown axis gives zeros and the error flag.
  assign one_e = ENT_W'(ONE_C);
  assign c_e   = ENT_W'(cv_q);
  assign s_e   = ENT_W'(sv_q);
  assign ns_e  = ENT_W'(-sv_q);

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m_d[k] = '0;
    end
    bad_d = 1'b0;
    case (axis_q[NSTAGE-1])
      rmg_pkg::AXIS_X: begin
        m_d[0] = one_e;
        m_d[4] = c_e;
        m_d[5] = ns_e;
        m_d[7] = s_e;
        m_d[8] = c_e;
      end
      rmg_pkg::AXIS_Y: begin
        m_d[0] = c_e;
        m_d[2] = s_e;
        m_d[4] = one_e;
        m_d[6] = ns_e;
        m_d[8] = c_e;
      end
      rmg_pkg::AXIS_Z: begin
        m_d[0] = c_e;
        m_d[1] = ns_e;
        m_d[3] = s_e;
        m_d[4] = c_e;
        m_d[8] = one_e;
      end
      default: begin
        bad_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q   <= m_d;
      bad_q <= bad_d;
    end
  end

  assign res_o.valid    = ovld_q;
  assign res_o.m00      = m_q[0];
  assign res_o.m01      = m_q[1];
  assign res_o.m02      = m_q[2];
  assign res_o.m10      = m_q[3];
  assign res_o.m11      = m_q[4];
  assign res_o.m12      = m_q[5];
  assign res_o.m20      = m_q[6];
  assign res_o.m21      = m_q[7];
  assign res_o.m22      = m_q[8];
  assign res_o.bad_axis = bad_q;

  // A flagged result carries zeros on the matrix diagonal.
  a_bad_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && bad_q) |-> (m_q[0] == '0 && m_q[4] == '0 && m_q[8] == '0))
    else $error("bad axis with nonzero matrix");

  // An item leaving the last stage lands in the result register.
  a_last_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && vld_q[NSTAGE-1]) |=> ovld_q)
    else $error("item lost at result register");

endmodule

FILE: bench/rmg_checker.sv
`timescale 1ns / 1ps
// Checker of the rotation matrix generator: watches both channels, predicts
// each matrix from the accepted request and compares it with the result.
// Depends on rmg_pkg and rmg_intf.
module rmg_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  rmg_in_if          req_i,
  rmg_out_if         res_i,
  output int         fail_count_o,
  output int         pending_o
);
  import rmg_pkg::*;

  typedef struct packed {
    logic [ENTRY_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic               bad_axis;
  } matrix_t;

  matrix_t matrix_q[$];

  // Floor shift of a signed value.
  function automatic longint floor_shift(input longint v, input int s);
    return v >>> s;
  endfunction

  // Rounds a Q.30 value to the output format and clamps it to one.
  function automatic longint round_entry(input longint q30);
    longint v;
    longint one;
    one = longint'(1) << OUT_FRAC_BITS;
    if (OUT_FRAC_BITS >= 30) v = q30;
    else v = floor_shift(q30 + (longint'(1) << (29 - OUT_FRAC_BITS)), 30 - OUT_FRAC_BITS);
    if (v > one) v = one;
    if (v < -one) v = -one;
    return v;
  endfunction

  // Computes the rotation matrix for one request.
  function automatic matrix_t rotation_matrix(input logic [31:0] ang,
                                              input logic [1:0] ax);
    longint a, r, x, y, z, dx, dy, at, c, s, cv, sv, one;
    longint full, quarter;
    int q;
    longint m[9];
    matrix_t res;
    full = longint'(360) << ANGLE_FRAC_BITS;
    quarter = longint'(90) << ANGLE_FRAC_BITS;
    a = longint'($signed(ang));
    r = a % full;
    if (r < 0) r += full;
    q = int'(r / quarter);
    r -= longint'(q) * quarter;
    x = 652032874;
    y = 0;
    z = (r * 74961321 + (longint'(1) << (ANGLE_FRAC_BITS + 1))) >>> (ANGLE_FRAC_BITS + 2);
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      at = (i < 31) ? longint'(atan_q30(i)) : 0;
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= at;
      end else begin
        x += dx; y -= dy; z += at;
      end
    end
    case (q & 3)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    cv = round_entry(c);
    sv = round_entry(s);
    one = longint'(1) << OUT_FRAC_BITS;
    foreach (m[k]) m[k] = 0;
    case (ax)
      AXIS_X: begin m[0] = one; m[4] = cv; m[5] = -sv; m[7] = sv; m[8] = cv; end
      AXIS_Y: begin m[0] = cv; m[2] = sv; m[4] = one; m[6] = -sv; m[8] = cv; end
      AXIS_Z: begin m[0] = cv; m[1] = -sv; m[3] = sv; m[4] = cv; m[8] = one; end
      default: ;
    endcase
    res.m00 = m[0][ENTRY_W-1:0]; res.m01 = m[1][ENTRY_W-1:0];
    res.m02 = m[2][ENTRY_W-1:0]; res.m10 = m[3][ENTRY_W-1:0];
    res.m11 = m[4][ENTRY_W-1:0]; res.m12 = m[5][ENTRY_W-1:0];
    res.m20 = m[6][ENTRY_W-1:0]; res.m21 = m[7][ENTRY_W-1:0];
    res.m22 = m[8][ENTRY_W-1:0];
    res.bad_axis = (ax != AXIS_X && ax != AXIS_Y && ax != AXIS_Z);
    return res;
  endfunction

  // Compares one result entry and reports a mismatch.
  task automatic check_field(input string name, input logic [ENTRY_W-1:0] exp_v,
                             input logic [ENTRY_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
               $signed(exp_v), $signed(act_v));
      fail_count_o++;
    end
  endtask

  assign pending_o = matrix_q.size();

  // Predicts on each accepted request and checks each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    matrix_t e;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (matrix_q.size() == 0) begin
          $display("%0t: result with no request waiting", $time);
          fail_count_o++;
        end else begin
          e = matrix_q.pop_front();
          check_field("m00", e.m00, res_i.m00);
          check_field("m01", e.m01, res_i.m01);
          check_field("m02", e.m02, res_i.m02);
          check_field("m10", e.m10, res_i.m10);
          check_field("m11", e.m11, res_i.m11);
          check_field("m12", e.m12, res_i.m12);
          check_field("m20", e.m20, res_i.m20);
          check_field("m21", e.m21, res_i.m21);
          check_field("m22", e.m22, res_i.m22);
          check_field("bad_axis", ENTRY_W'(e.bad_axis), ENTRY_W'(res_i.bad_axis));
        end
      end
      if (req_i.valid && req_i.ready)
        matrix_q.push_back(rotation_matrix(req_i.angle_deg, req_i.axis));
    end
  end
endmodule

FILE: bench/tb_axis_rotation_matrix_gen.sv
`timescale 1ns / 1ps
// Testbench top of the rotation matrix generator: drives angle requests with
// random gaps and back pressure and gives the verdict. Depends on rmg_pkg,
// rmg_intf, rmg_checker and the block.
module tb_axis_rotation_matrix_gen;
  import rmg_pkg::*;

  localparam int N_RANDOM   = 950;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  bit   calm = 1'b0;

  rmg_in_if  req_if ();
  rmg_out_if res_if ();

  axis_rotation_matrix_gen uut (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if), .res_o(res_if));
  rmg_checker checker_i (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_if), .res_i(res_if),
                         .fail_count_o(fail_count), .pending_o(pending));

  always #5 clk_i = ~clk_i;

  initial begin
    req_if.valid = 1'b0;
    req_if.angle_deg = '0;
    req_if.axis = AXIS_X;
    res_if.ready = 1'b0;
  end

  // Result side stalls at random, except during the calm stretch.
  always @(posedge clk_i) res_if.ready <= calm || ($urandom_range(99) >= 34);

  // Cycle limit guards against a hung block.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Presents one request and holds it until accepted. Valid stays high after
  // the accepting edge so that a following request can go out back to back;
  // it drops only while the source idles.
  task automatic send_request(input logic [31:0] ang, input logic [1:0] ax);
    while (!calm && $urandom_range(99) < 34) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.angle_deg <= ang;
    req_if.axis <= ax;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Picks an angle: mostly ordinary turns, sometimes raw 32-bit patterns.
  function automatic logic [31:0] random_angle();
    int sel;
    sel = $urandom_range(9);
    if (sel < 3) return $urandom();
    if (sel < 5) return 32'($urandom_range(359)) << 16;
    if (sel < 6) return (32'($urandom_range(3)) * 90 << 16) + 32'($urandom_range(3))
                        - 32'd1;
    return 32'($signed($urandom_range(1440)) - 720) * 65536 + 32'($urandom_range(65535));
  endfunction

  initial begin
    logic [31:0] angle_set[$];
    int wait_cycles;
    angle_set = '{32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1,
                  32'd90 << 16, 32'd180 << 16, 32'd270 << 16, 32'd360 << 16,
                  -(32'd90 << 16), -(32'd360 << 16), (32'd90 << 16) - 1, 32'd45 << 16};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: angle extremes and quadrant edges, axis codes taken in turn.
    foreach (angle_set[k]) send_request(angle_set[k], 2'(k % 4));
    for (int ax = 0; ax < 4; ax++) send_request(32'd30 << 16, 2'(ax));
    // Random part, with a stretch of back-to-back traffic in the middle.
    for (int n = 0; n < N_RANDOM; n++) begin
      calm = (n >= 400 && n < 520);
      send_request(random_angle(), 2'($urandom_range(3)));
    end
    req_if.valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk_i);
    wait_cycles = 0;
    while (wait_cycles < 64) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
